### sv/lmgs_pkg.sv
`timescale 1ns / 1ps
package lmgs_pkg;

  localparam int ROWS        = 12;
  localparam int GLYPH_COUNT = 16;
  localparam int GLYPH_WIDTH = 12;
  localparam int ROW_W       = 4;
  localparam int GLYPH_W     = 4;
  localparam int TICK_W      = 32;
  localparam int PERIOD_W    = 16;
  localparam int FONT_BYTES  = 2 * ROWS;

  localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RESET = 16'd800;
  localparam logic [GLYPH_W-1:0]  GLYPH_MAX = GLYPH_W'(GLYPH_COUNT - 2);

  // register index of the configuration space
  localparam logic REG_BLINK_PERIOD = 1'b0;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_REFRESH = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               cmd;
    logic [GLYPH_W-1:0] glyph_index;
    logic               glyph_color;
    logic [TICK_W-1:0]  now_ticks;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0]       row_number;
    logic                   color;
    logic [GLYPH_WIDTH-1:0] left_bits;
    logic [GLYPH_WIDTH-1:0] right_bits;
    logic                   last_row;
  } out_word_t;

  // classified work handed from the front to the back
  typedef struct packed {
    logic               cmd;
    logic [GLYPH_W-1:0] glyph;
    logic               color;
    logic               mark;
  } job_t;

  localparam logic [7:0] FONT_ROM [GLYPH_COUNT][FONT_BYTES] = '{
    '{8'h11,8'h00,8'h21,8'h00,8'h47,8'hC0,8'h91,8'h00,8'h2F,8'hE0,8'h60,8'h80,
      8'hAF,8'hE0,8'h20,8'h80,8'h24,8'h80,8'h22,8'h80,8'h20,8'h80,8'h23,8'h80},
    '{8'h20,8'h00,8'h27,8'h80,8'h24,8'h80,8'hF4,8'h80,8'h24,8'h80,8'h74,8'h80,
      8'h6C,8'h80,8'hA4,8'h80,8'h24,8'h80,8'h24,8'hA0,8'h28,8'hA0,8'h30,8'h60},
    '{8'h11,8'h00,8'h1F,8'hE0,8'h20,8'h00,8'h27,8'hC0,8'h64,8'h40,8'hA7,8'hC0,
      8'h20,8'h00,8'h2F,8'hE0,8'h28,8'h20,8'h27,8'hC0,8'h21,8'h00,8'h23,8'h00},
    '{8'h00,8'h80,8'hF0,8'h80,8'h13,8'hE0,8'h52,8'hA0,8'h52,8'hA0,8'h52,8'hA0,
      8'h7B,8'hE0,8'h0C,8'h80,8'h2A,8'h80,8'hC9,8'h00,8'h0A,8'h80,8'h34,8'h60},
    '{8'h08,8'h00,8'h04,8'h00,8'hFF,8'hE0,8'h91,8'h20,8'h20,8'h80,8'h40,8'h40,
      8'h00,8'h00,8'h7F,8'hC0,8'h04,8'h00,8'h04,8'h00,8'h04,8'h00,8'hFF,8'hE0},
    '{8'h08,8'h00,8'h08,8'h00,8'hFF,8'hE0,8'h10,8'h00,8'h24,8'h00,8'h44,8'h00,
      8'h7F,8'hC0,8'h04,8'h00,8'h04,8'h00,8'hFF,8'hE0,8'h04,8'h00,8'h04,8'h00},
    '{8'h08,8'h00,8'h08,8'h00,8'hFF,8'hE0,8'h10,8'h00,8'h3F,8'hC0,8'h60,8'h40,
      8'hBF,8'hC0,8'h20,8'h40,8'h3F,8'hC0,8'h20,8'h40,8'h20,8'h40,8'h20,8'hC0},
    '{8'h04,8'h00,8'h04,8'h00,8'h04,8'h00,8'h04,8'h00,8'h04,8'h00,8'h0A,8'h00,
      8'h0A,8'h00,8'h11,8'h00,8'h11,8'h00,8'h20,8'h80,8'h40,8'h40,8'h80,8'h20},
    '{8'h19,8'h80,8'h1F,8'hF0,8'h30,8'h00,8'h37,8'hE0,8'h76,8'h60,8'hF7,8'hE0,
      8'h30,8'h00,8'h3F,8'hF0,8'h3C,8'h30,8'h37,8'hE0,8'h31,8'h80,8'h33,8'h80},
    '{8'h00,8'hC0,8'hF8,8'hC0,8'h1B,8'hF0,8'h7B,8'hF0,8'h7B,8'hF0,8'h7B,8'hF0,
      8'h7F,8'hF0,8'h0E,8'hC0,8'h3F,8'hC0,8'hED,8'h80,8'h0F,8'hC0,8'h3E,8'h70},
    '{8'h0C,8'h00,8'h06,8'h00,8'hFF,8'hF0,8'hD9,8'hB0,8'h30,8'hC0,8'h60,8'h60,
      8'h00,8'h00,8'h7F,8'hE0,8'h06,8'h00,8'h06,8'h00,8'h06,8'h00,8'hFF,8'hF0},
    '{8'h0C,8'h00,8'h0C,8'h00,8'hFF,8'hF0,8'h18,8'h00,8'h36,8'h00,8'h66,8'h00,
      8'h7F,8'hE0,8'h06,8'h00,8'h06,8'h00,8'hFF,8'hF0,8'h06,8'h00,8'h06,8'h00},
    '{8'h19,8'h80,8'h31,8'h80,8'h67,8'hE0,8'hD9,8'h80,8'h3F,8'hF0,8'h70,8'hC0,
      8'hFF,8'hF0,8'h30,8'hC0,8'h36,8'hC0,8'h33,8'hC0,8'h30,8'hC0,8'h33,8'hC0},
    '{8'h30,8'h00,8'h37,8'hC0,8'h36,8'hC0,8'hFE,8'hC0,8'h36,8'hC0,8'h7E,8'hC0,
      8'h7E,8'hC0,8'hF6,8'hC0,8'h36,8'hC0,8'h36,8'hF0,8'h3C,8'hF0,8'h38,8'h70},
    '{8'h00,8'h00,8'h7F,8'hE0,8'h06,8'h00,8'h06,8'h00,8'h06,8'h00,8'hFF,8'hF0,
      8'h0F,8'h00,8'h0F,8'h00,8'h1B,8'h00,8'h33,8'h30,8'h63,8'h30,8'hC1,8'hF0},
    '{8'h06,8'h00,8'h06,8'h00,8'h06,8'h00,8'h06,8'h00,8'h06,8'h00,8'h0F,8'h00,
      8'h0F,8'h00,8'h19,8'h80,8'h19,8'h80,8'h30,8'hC0,8'h60,8'h60,8'hC0,8'h30}
  };

  // row word: high byte above the top nibble of the low byte
  function automatic logic [GLYPH_WIDTH-1:0] rom_row(input logic [GLYPH_W-1:0] glyph,
                                                     input logic [ROW_W-1:0]   row);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = FONT_ROM[glyph][{row, 1'b0}];
    lo = FONT_ROM[glyph][{row, 1'b1}];
    return {hi, lo[7:4]};
  endfunction

endpackage

### sv/led_matrix_glyph_scanner_core.sv
`timescale 1ns / 1ps
// A refresh's first row word passes the job queue, back-end state register and output queue.
// Jobs run one at a time: the back-end row sequencer takes a job only while idle, then handles
//   one frame buffer row per cycle, on a refresh only while the output queue has room.
// Output stalls hold the scan; the front keeps taking words until its two-entry job queue fills.
// Reset (synchronous, rst_n low): frame buffer, colour, blink phase and tick mark clear,
//   blink_period returns to 800, both queues empty.
module led_matrix_glyph_scanner_core (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_push,
  input  lmgs_pkg::in_word_t   in_word,
  output logic                 in_full,
  // result channel
  output logic                 out_empty,
  input  logic                 out_pop,
  output lmgs_pkg::out_word_t  out_word,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int JOB_W = $bits(lmgs_pkg::job_t);
  localparam int OUT_W = $bits(lmgs_pkg::out_word_t);

  logic [lmgs_pkg::PERIOD_W-1:0] blink_period_r, blink_period_nxt;
  logic                          cfg_write;

  logic                          job_push, job_full, job_empty, job_pop;
  lmgs_pkg::job_t                job_in, job_out;
  logic [JOB_W-1:0]              job_out_bits;

  logic                          res_push, res_full;
  lmgs_pkg::out_word_t           res_word;
  logic [OUT_W-1:0]              res_out_bits;

  // Configuration: word address in paddr[2]; only the blink period lives here.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == lmgs_pkg::REG_BLINK_PERIOD);

  always_comb begin
    blink_period_nxt = blink_period_r;
    if (cfg_write) begin
      blink_period_nxt = pwdata[lmgs_pkg::PERIOD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lmgs_pkg::REG_BLINK_PERIOD) begin
      prdata = 32'(blink_period_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_period_r <= lmgs_pkg::BLINK_PERIOD_RESET;
    end else begin
      blink_period_r <= blink_period_nxt;
    end
  end

  // Front: classify the word, saturate the glyph, settle the blink phase.
  lmgs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_word      (in_word),
    .in_full      (in_full),
    .blink_period (blink_period_r),
    .job_push     (job_push),
    .job_word     (job_in),
    .job_full     (job_full)
  );

  // Short job queue decoupling the front from the row sequencer.
  lmgs_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out_bits),
    .empty (job_empty)
  );

  assign job_out = lmgs_pkg::job_t'(job_out_bits);

  // Back: fill the frame buffer on a load, walk the rows on a refresh.
  lmgs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_word  (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .out_push  (res_push),
    .out_word  (res_word),
    .out_full  (res_full)
  );

  // Output skid queue: the scan advances while an earlier row word waits.
  lmgs_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_word),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out_bits),
    .empty (out_empty)
  );

  assign out_word = lmgs_pkg::out_word_t'(res_out_bits);

endmodule

### sv/lmgs_fifo.sv
`timescale 1ns / 1ps
module lmgs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### sv/lmgs_front.sv
`timescale 1ns / 1ps
module lmgs_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  lmgs_pkg::in_word_t                in_word,
  output logic                              in_full,
  input  logic [lmgs_pkg::PERIOD_W-1:0]     blink_period,
  output logic                              job_push,
  output lmgs_pkg::job_t                    job_word,
  input  logic                              job_full
);

  logic [lmgs_pkg::TICK_W-1:0] last_toggle_r, last_toggle_nxt;
  logic                        phase_r, phase_nxt;
  logic [lmgs_pkg::TICK_W-1:0] elapsed;
  logic                        refresh;
  logic                        toggle;

  assign in_full  = job_full;
  assign job_push = in_push && !job_full;
  assign refresh  = (in_word.cmd == lmgs_pkg::CMD_REFRESH);
  assign elapsed  = in_word.now_ticks - last_toggle_r;
  assign toggle   = refresh && (elapsed >= lmgs_pkg::TICK_W'(blink_period));

  always_comb begin
    last_toggle_nxt = last_toggle_r;
    phase_nxt       = phase_r;
    if (job_push && toggle) begin
      last_toggle_nxt = in_word.now_ticks;
      phase_nxt       = !phase_r;
    end
  end

  // saturate the left glyph so its right neighbour stays in the font
  always_comb begin
    job_word.cmd   = in_word.cmd;
    job_word.glyph = (in_word.glyph_index > lmgs_pkg::GLYPH_MAX) ?
                     lmgs_pkg::GLYPH_MAX : in_word.glyph_index;
    job_word.color = in_word.glyph_color;
    job_word.mark  = !(toggle ? !phase_r : phase_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_toggle_r <= '0;
      phase_r       <= 1'b0;
    end else begin
      last_toggle_r <= last_toggle_nxt;
      phase_r       <= phase_nxt;
    end
  end

endmodule

### sv/lmgs_back.sv
`timescale 1ns / 1ps
module lmgs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lmgs_pkg::job_t       job_word,
  input  logic                 job_empty,
  output logic                 job_pop,
  output logic                 out_push,
  output lmgs_pkg::out_word_t  out_word,
  input  logic                 out_full
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  localparam int GW = lmgs_pkg::GLYPH_WIDTH;
  localparam logic [lmgs_pkg::ROW_W-1:0] ROW_LAST = lmgs_pkg::ROW_W'(lmgs_pkg::ROWS - 1);
  localparam logic [GW-1:0] LEFT_MARK  = GW'(1) << (GW - 1);
  localparam logic [GW-1:0] RIGHT_MARK = GW'(1);

  state_t                        state_r, state_nxt;
  lmgs_pkg::job_t                job_r, job_nxt;
  logic [lmgs_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic                          color_r, color_nxt;
  logic [GW-1:0]                 fb_left_r  [lmgs_pkg::ROWS];
  logic [GW-1:0]                 fb_right_r [lmgs_pkg::ROWS];
  logic                          fb_we;
  logic [GW-1:0]                 fb_left_wd, fb_right_wd;
  logic [GW-1:0]                 cur_left, cur_right;
  logic                          corner;
  logic [lmgs_pkg::GLYPH_W-1:0]  right_glyph;

  assign right_glyph = job_r.glyph + 1'b1;
  assign corner      = (row_r == '0) || (row_r == ROW_LAST);

  // apply the corner markers on the way out and keep them in the buffer
  always_comb begin
    cur_left  = fb_left_r[row_r];
    cur_right = fb_right_r[row_r];
    if (corner) begin
      if (job_r.mark) begin
        cur_left  = cur_left | LEFT_MARK;
        cur_right = cur_right | RIGHT_MARK;
      end else begin
        cur_left  = cur_left & ~LEFT_MARK;
        cur_right = cur_right & ~RIGHT_MARK;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    job_nxt     = job_r;
    row_nxt     = row_r;
    color_nxt   = color_r;
    job_pop     = 1'b0;
    out_push    = 1'b0;
    fb_we       = 1'b0;
    fb_left_wd  = cur_left;
    fb_right_wd = cur_right;
    unique case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          job_pop = 1'b1;
          job_nxt = job_word;
          row_nxt = '0;
          if (job_word.cmd == lmgs_pkg::CMD_LOAD) begin
            color_nxt = job_word.color;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LOAD: begin
        fb_we       = 1'b1;
        fb_left_wd  = lmgs_pkg::rom_row(job_r.glyph, row_r);
        fb_right_wd = lmgs_pkg::rom_row(right_glyph, row_r);
        if (row_r == ROW_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      ST_SCAN: begin
        if (!out_full) begin
          out_push = 1'b1;
          fb_we    = corner;
          if (row_r == ROW_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_word.row_number = row_r + 1'b1;
    out_word.color      = color_r;
    out_word.left_bits  = cur_left;
    out_word.right_bits = cur_right;
    out_word.last_row   = (row_r == ROW_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      color_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      color_r <= color_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lmgs_pkg::ROWS; i++) begin
        fb_left_r[i]  <= '0;
        fb_right_r[i] <= '0;
      end
    end else if (fb_we) begin
      fb_left_r[row_r]  <= fb_left_wd;
      fb_right_r[row_r] <= fb_right_wd;
    end
  end

  a_push_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> (state_r == ST_SCAN))
    else $error("row word pushed outside a scan");

  a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && out_word.last_row) |=> (state_r == ST_IDLE))
    else $error("scan did not end after the last row");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (state_r == ST_IDLE) && !job_empty)
    else $error("job taken while busy");

endmodule
